>>> rtl/core/ssfe_pkg.sv
`default_nettype none

package ssfe_pkg;

    localparam int MAX_DIGITS = 6;
    localparam int GLYPH_W    = 5;
    localparam int SEG_IDX_W  = 3;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FLIP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR = 2'd1;

    localparam logic [7:0] DATA_MODE_CMD = 8'h40;
    localparam logic [7:0] ADDR_CMD      = 8'hC0;
    localparam logic [7:0] DISPLAY_OFF   = 8'h80;
    localparam logic [7:0] DISPLAY_ON    = 8'h88;
    localparam logic [7:0] COLON_BIT     = 8'h80;
    localparam logic [2:0] MAX_LEVEL     = 3'd7;

    typedef struct packed {
        logic [MAX_DIGITS-1:0][GLYPH_W-1:0] glyph;
        logic                               colon_on;
        logic                               blank_display;
        logic [7:0]                         brightness;
    } frame_t;

    typedef struct packed {
        logic [MAX_DIGITS-1:0][7:0] seg;
        logic                       colon_on;
        logic                       blank_display;
        logic [2:0]                 level;
    } seg_frame_t;

    typedef struct packed {
        logic [MAX_DIGITS-1:0][7:0] seg;
        logic [7:0]                 ctrl;
    } byte_frame_t;

    // Segment pattern for each glyph index; index 31 shows nothing.
    function automatic logic [7:0] glyph_code(input logic [GLYPH_W-1:0] idx);
        logic [7:0] code;
        case (idx)
            5'd0:    code = 8'h3F;
            5'd1:    code = 8'h06;
            5'd2:    code = 8'h5B;
            5'd3:    code = 8'h4F;
            5'd4:    code = 8'h66;
            5'd5:    code = 8'h6D;
            5'd6:    code = 8'h7D;
            5'd7:    code = 8'h07;
            5'd8:    code = 8'h7F;
            5'd9:    code = 8'h6F;
            5'd10:   code = 8'h77;
            5'd11:   code = 8'h7C;
            5'd12:   code = 8'h39;
            5'd13:   code = 8'h5E;
            5'd14:   code = 8'h79;
            5'd15:   code = 8'h71;
            5'd16:   code = 8'h76;
            5'd17:   code = 8'h38;
            5'd18:   code = 8'h50;
            5'd19:   code = 8'h73;
            5'd20:   code = 8'h37;
            5'd21:   code = 8'h40;
            5'd22:   code = 8'h01;
            5'd23:   code = 8'h08;
            5'd24:   code = 8'h63;
            5'd25:   code = 8'h5C;
            5'd26:   code = 8'h3E;
            5'd27:   code = 8'h58;
            5'd28:   code = 8'h6B;
            5'd29:   code = 8'h5D;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/ssfe_if.sv
`default_nettype none

interface ssfe_frame_if;
    logic       valid;
    logic       ready;
    logic [4:0] glyph_0;
    logic [4:0] glyph_1;
    logic [4:0] glyph_2;
    logic [4:0] glyph_3;
    logic [4:0] glyph_4;
    logic [4:0] glyph_5;
    logic       colon_on;
    logic       blank_display;
    logic [7:0] brightness;

    modport source (
        output valid, glyph_0, glyph_1, glyph_2, glyph_3, glyph_4, glyph_5,
               colon_on, blank_display, brightness,
        input  ready
    );
    modport sink (
        input  valid, glyph_0, glyph_1, glyph_2, glyph_3, glyph_4, glyph_5,
               colon_on, blank_display, brightness,
        output ready
    );
endinterface

interface ssfe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       end_of_transfer;
    logic       last;

    modport source (output valid, out_byte, end_of_transfer, last, input ready);
    modport sink (input valid, out_byte, end_of_transfer, last, output ready);
endinterface

interface ssfe_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic       data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ssfe_lookup.sv
`default_nettype none

module ssfe_lookup
    import ssfe_pkg::*;
#(
    parameter int DIGITS = 6
)(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       flip,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire frame_t     in_frame,
    output logic            out_valid,
    input  wire logic       out_ready,
    output seg_frame_t      out_frame
);

    // Rotating by 180 degrees moves a->d, b->e, c->f and back; g stays.
    function automatic logic [7:0] rotate_segments(input logic [7:0] s);
        return {1'b0, s[6], s[2], s[1], s[0], s[5], s[4], s[3]};
    endfunction

    logic       cap_valid_reg;
    frame_t     cap_frame_reg;
    logic       seg_valid_reg;
    seg_frame_t seg_frame_reg;
    seg_frame_t seg_frame_next;
    logic       cap_ready;
    logic       seg_ready;

    logic [MAX_DIGITS-1:0][7:0] seg_next;

    assign seg_ready = !seg_valid_reg || out_ready;
    assign cap_ready = !cap_valid_reg || seg_ready;
    assign in_ready  = cap_ready;

    // Segment byte k+1 shows the last glyph first unless the display is flipped.
    for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_slot
        if (k < DIGITS) begin : g_used
            assign seg_next[k] = flip ? rotate_segments(glyph_code(cap_frame_reg.glyph[k]))
                                      : glyph_code(cap_frame_reg.glyph[DIGITS-1-k]);
        end
        else begin : g_unused
            assign seg_next[k] = 8'h00;
        end
    end

    always_comb
    begin
        seg_frame_next.seg           = seg_next;
        seg_frame_next.colon_on      = cap_frame_reg.colon_on;
        seg_frame_next.blank_display = cap_frame_reg.blank_display;
        seg_frame_next.level         = (cap_frame_reg.brightness > 8'(MAX_LEVEL))
                                       ? MAX_LEVEL : cap_frame_reg.brightness[2:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_valid_reg <= 1'b0;
            seg_valid_reg <= 1'b0;
        end
        else
        begin
            if (cap_ready)
                cap_valid_reg <= in_valid;
            if (seg_ready)
                seg_valid_reg <= cap_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap_ready && in_valid)
            cap_frame_reg <= in_frame;
        if (seg_ready && cap_valid_reg)
            seg_frame_reg <= seg_frame_next;
    end

    assign out_valid = seg_valid_reg;
    assign out_frame = seg_frame_reg;

endmodule

`default_nettype wire

>>> rtl/core/ssfe_format.sv
`default_nettype none

module ssfe_format
    import ssfe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       mirror,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire seg_frame_t in_frame,
    output logic            out_valid,
    input  wire logic       out_ready,
    output byte_frame_t     out_frame
);

    // Top-to-bottom flip swaps a/d, b/c and e/f; g and the colon bit stay.
    function automatic logic [7:0] mirror_segments(input logic [7:0] s);
        return {s[7], s[6], s[4], s[5], s[0], s[1], s[2], s[3]};
    endfunction

    logic        fmt_valid_reg;
    byte_frame_t fmt_frame_reg;
    byte_frame_t fmt_frame_next;

    assign in_ready = !fmt_valid_reg || out_ready;

    always_comb
    begin
        for (int k = 0; k < MAX_DIGITS; k++)
        begin
            fmt_frame_next.seg[k] = mirror ? mirror_segments(in_frame.seg[k])
                                           : in_frame.seg[k];
            // Colon dots sit on the second and fourth segment bytes.
            if (in_frame.colon_on && (k == 1 || k == 3))
                fmt_frame_next.seg[k] = fmt_frame_next.seg[k] | COLON_BIT;
        end
        fmt_frame_next.ctrl = in_frame.blank_display ? DISPLAY_OFF
                                                     : (DISPLAY_ON | {5'b0, in_frame.level});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fmt_valid_reg <= 1'b0;
        else if (in_ready)
            fmt_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            fmt_frame_reg <= fmt_frame_next;
    end

    assign out_valid = fmt_valid_reg;
    assign out_frame = fmt_frame_reg;

endmodule

`default_nettype wire

>>> rtl/core/ssfe_serializer.sv
`default_nettype none

module ssfe_serializer
    import ssfe_pkg::*;
#(
    parameter int DIGITS = 6
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire byte_frame_t in_frame,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             end_of_transfer,
    output logic             last
);

    localparam int               CNT_W    = $clog2(DIGITS + 3);
    localparam logic [CNT_W-1:0] ADDR_CNT = CNT_W'(1);
    localparam logic [CNT_W-1:0] SEG_END  = CNT_W'(DIGITS + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DIGITS + 2);

    logic                 busy_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    byte_frame_t          frame_reg;
    logic [SEG_IDX_W-1:0] seg_idx;
    logic                 byte_taken;
    logic                 frame_done;
    logic                 load;

    assign byte_taken = busy_reg && out_ready;
    assign frame_done = byte_taken && (cnt_reg == LAST_CNT);
    // A new frame is taken while the control byte of the current one leaves.
    assign in_ready   = !busy_reg || frame_done;
    assign load       = in_ready && in_valid;
    assign cnt_next   = cnt_reg + CNT_W'(1);
    assign seg_idx    = SEG_IDX_W'(cnt_reg - CNT_W'(2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (frame_done)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (byte_taken)
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            frame_reg <= in_frame;
    end

    always_comb
    begin
        end_of_transfer = 1'b0;
        last            = 1'b0;
        if (cnt_reg == '0)
        begin
            out_byte        = DATA_MODE_CMD;
            end_of_transfer = 1'b1;
        end
        else if (cnt_reg == ADDR_CNT)
        begin
            out_byte = ADDR_CMD;
        end
        else if (cnt_reg == LAST_CNT)
        begin
            out_byte        = frame_reg.ctrl;
            end_of_transfer = 1'b1;
            last            = 1'b1;
        end
        else
        begin
            out_byte        = frame_reg.seg[seg_idx];
            end_of_transfer = (cnt_reg == SEG_END);
        end
    end

    assign out_valid = busy_reg;

endmodule

`default_nettype wire

>>> rtl/core/six_digit_segment_frame_encoder.sv
// The first byte of a frame is offered once it has passed the capture, segment and format
// registers and been loaded into the serializer. A frame is DIGITS + 3 bytes (nine at the
// default), sent one byte per cycle while result.ready is high; up to three more frames
// wait in the stages. Reset: rst_n is asynchronous and active low; it empties every stage
// and clears the flip and mirror settings.
`default_nettype none

module six_digit_segment_frame_encoder
    import ssfe_pkg::*;
#(
    parameter int DIGITS = 6
)(
    input  wire logic   clk,
    input  wire logic   rst_n,
    ssfe_frame_if.sink  frame,
    ssfe_byte_if.source result,
    ssfe_cfg_if.sink    cfg
);

    logic        flip_reg;
    logic        mirror_reg;
    frame_t      in_frame;
    logic        seg_valid;
    logic        seg_ready;
    seg_frame_t  seg_frame;
    logic        fmt_valid;
    logic        fmt_ready;
    byte_frame_t fmt_frame;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_reg   <= 1'b0;
            mirror_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_FLIP:   flip_reg   <= cfg.data;
                CFG_MIRROR: mirror_reg <= cfg.data;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        in_frame.glyph[0]      = frame.glyph_0;
        in_frame.glyph[1]      = frame.glyph_1;
        in_frame.glyph[2]      = frame.glyph_2;
        in_frame.glyph[3]      = frame.glyph_3;
        in_frame.glyph[4]      = frame.glyph_4;
        in_frame.glyph[5]      = frame.glyph_5;
        in_frame.colon_on      = frame.colon_on;
        in_frame.blank_display = frame.blank_display;
        in_frame.brightness    = frame.brightness;
    end

    ssfe_lookup #(
        .DIGITS (DIGITS)
    ) u_lookup (
        .clk       (clk),
        .rst_n     (rst_n),
        .flip      (flip_reg),
        .in_valid  (frame.valid),
        .in_ready  (frame.ready),
        .in_frame  (in_frame),
        .out_valid (seg_valid),
        .out_ready (seg_ready),
        .out_frame (seg_frame)
    );

    ssfe_format u_format (
        .clk       (clk),
        .rst_n     (rst_n),
        .mirror    (mirror_reg),
        .in_valid  (seg_valid),
        .in_ready  (seg_ready),
        .in_frame  (seg_frame),
        .out_valid (fmt_valid),
        .out_ready (fmt_ready),
        .out_frame (fmt_frame)
    );

    ssfe_serializer #(
        .DIGITS (DIGITS)
    ) u_serializer (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (fmt_valid),
        .in_ready        (fmt_ready),
        .in_frame        (fmt_frame),
        .out_valid       (result.valid),
        .out_ready       (result.ready),
        .out_byte        (result.out_byte),
        .end_of_transfer (result.end_of_transfer),
        .last            (result.last)
    );

endmodule

`default_nettype wire

>>> rtl/core/ssfe_checker.sv
`default_nettype none

module ssfe_checker
    import ssfe_pkg::*;
#(
    parameter int DIGITS = 6
)(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       valid,
    input wire logic       ready,
    input wire logic [7:0] out_byte,
    input wire logic       end_of_transfer,
    input wire logic       last
);

    localparam int               POS_W    = $clog2(DIGITS + 3);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(DIGITS + 2);

    logic [POS_W-1:0] pos_reg;
    logic             taken;

    assign taken = valid && ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (taken)
            pos_reg <= (pos_reg == LAST_POS) ? '0 : pos_reg + POS_W'(1);
    end

    // A stalled request keeps its byte.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(out_byte) && $stable(last))
        else $error("result request changed while stalled");

    // Every frame opens with the data-mode command as a transfer of its own.
    a_open: assert property (@(posedge clk) disable iff (!rst_n)
        valid && pos_reg == '0 |-> out_byte == DATA_MODE_CMD && end_of_transfer && !last)
        else $error("frame does not start with the data-mode command");

    // The address command follows and does not close its transfer.
    a_addr: assert property (@(posedge clk) disable iff (!rst_n)
        valid && pos_reg == POS_W'(1) |-> out_byte == ADDR_CMD && !end_of_transfer)
        else $error("address command missing");

    // The frame closes exactly at its final byte with a display-control command.
    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (last == (pos_reg == LAST_POS))
                  && (!last || (end_of_transfer && out_byte[7]
                                && (out_byte == DISPLAY_OFF || out_byte[3]))))
        else $error("frame end misplaced or control byte malformed");

endmodule

bind six_digit_segment_frame_encoder ssfe_checker #(
    .DIGITS (DIGITS)
) u_ssfe_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .valid           (result.valid),
    .ready           (result.ready),
    .out_byte        (result.out_byte),
    .end_of_transfer (result.end_of_transfer),
    .last            (result.last)
);

`default_nettype wire

>>> tb/sv/tb_six_digit_segment_frame_encoder.sv
`timescale 1ns / 1ps

module tb_six_digit_segment_frame_encoder;
    import ssfe_pkg::*;

    localparam int DIGITS       = 6;
    localparam int DRAIN_CYCLES = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam logic [GLYPH_W-1:0]   GLYPH_BLANK = 5'd31;

    localparam logic [7:0] SEG_PATTERN [0:30] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71,
        8'h76, 8'h38, 8'h50, 8'h73, 8'h37, 8'h40, 8'h01, 8'h08,
        8'h63, 8'h5C, 8'h3E, 8'h58, 8'h6B, 8'h5D, 8'h00
    };

    typedef struct packed {
        logic [7:0] data;
        logic       eot;
        logic       fin;
    } disp_byte_t;

    logic clk;
    logic rst_n;

    ssfe_frame_if frame_ch ();
    ssfe_byte_if  byte_ch ();
    ssfe_cfg_if   cfg_ch ();

    six_digit_segment_frame_encoder #(
        .DIGITS(DIGITS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_ch),
        .result (byte_ch),
        .cfg    (cfg_ch)
    );

    disp_byte_t expected_bytes [$];
    logic       flip_setting;
    logic       mirror_setting;
    int         src_idle_pct;
    int         sink_idle_pct;
    int         error_count;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("six_digit_segment_frame_encoder test failed");
        $finish;
    end

    function automatic logic [7:0] glyph_segments(input logic [GLYPH_W-1:0] idx);
        if (idx == GLYPH_BLANK)
            return 8'h00;
        return SEG_PATTERN[idx];
    endfunction

    // Rotation by 180 degrees swaps a/d, b/e and c/f; segment g stays.
    function automatic logic [7:0] rotate_180(input logic [7:0] s);
        return {1'b0, s[6], s[2], s[1], s[0], s[5], s[4], s[3]};
    endfunction

    function automatic logic [7:0] mirror_vertical(input logic [7:0] s);
        return {s[7], s[6], s[4], s[5], s[0], s[1], s[2], s[3]};
    endfunction

    function automatic void push_expected(input logic [7:0] data, input logic eot,
                                          input logic fin);
        disp_byte_t b;
        b.data = data;
        b.eot  = eot;
        b.fin  = fin;
        expected_bytes.push_back(b);
    endfunction

    function automatic void predict_frame_bytes(input frame_t f);
        logic [7:0] seg;
        logic [2:0] level;
        push_expected(DATA_MODE_CMD, 1'b1, 1'b0);
        push_expected(ADDR_CMD, 1'b0, 1'b0);
        for (int k = 1; k <= DIGITS; k++)
        begin
            if (flip_setting)
                seg = rotate_180(glyph_segments(f.glyph[k-1]));
            else
                seg = glyph_segments(f.glyph[DIGITS-k]);
            if (mirror_setting)
                seg = mirror_vertical(seg);
            if (f.colon_on && (k == 2 || k == 4))
                seg = seg | COLON_BIT;
            push_expected(seg, k == DIGITS, 1'b0);
        end
        level = (f.brightness > MAX_LEVEL) ? MAX_LEVEL : f.brightness[2:0];
        if (f.blank_display)
            push_expected(DISPLAY_OFF, 1'b1, 1'b1);
        else
            push_expected(DISPLAY_ON | {5'b0, level}, 1'b1, 1'b1);
    endfunction

    function automatic frame_t random_frame();
        frame_t f;
        for (int d = 0; d < MAX_DIGITS; d++)
            f.glyph[d] = 5'($urandom_range(31));
        f.colon_on      = 1'($urandom_range(1));
        f.blank_display = ($urandom_range(3) == 0);
        // Half of the requests stay near the saturation point.
        f.brightness = ($urandom_range(1) != 0) ? 8'($urandom_range(15))
                                                : 8'($urandom_range(255));
        return f;
    endfunction

    function automatic frame_t make_frame(input int g0, input int step, input logic colon,
                                          input logic blank, input logic [7:0] bright);
        frame_t f;
        for (int d = 0; d < MAX_DIGITS; d++)
            f.glyph[d] = ((g0 + d * step) > 31) ? 5'd31 : 5'(g0 + d * step);
        f.colon_on      = colon;
        f.blank_display = blank;
        f.brightness    = bright;
        return f;
    endfunction

    // Valid is left high after a request so back-to-back requests never see a dip.
    task automatic send_frame(input frame_t f);
        while ($urandom_range(99) < src_idle_pct)
        begin
            frame_ch.valid <= 1'b0;
            @(posedge clk);
        end
        frame_ch.valid         <= 1'b1;
        frame_ch.glyph_0       <= f.glyph[0];
        frame_ch.glyph_1       <= f.glyph[1];
        frame_ch.glyph_2       <= f.glyph[2];
        frame_ch.glyph_3       <= f.glyph[3];
        frame_ch.glyph_4       <= f.glyph[4];
        frame_ch.glyph_5       <= f.glyph[5];
        frame_ch.colon_on      <= f.colon_on;
        frame_ch.blank_display <= f.blank_display;
        frame_ch.brightness    <= f.brightness;
        @(posedge clk);
        while (!frame_ch.ready)
            @(posedge clk);
        predict_frame_bytes(f);
    endtask

    task automatic wait_drained();
        frame_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic data,
                             input bit keep_valid);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (idx == CFG_FLIP)
            flip_setting = data;
        else if (idx == CFG_MIRROR)
            mirror_setting = data;
        if (!keep_valid)
            cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_display_mode(input logic flip, input logic mirror);
        wait_drained();
        cfg_write(CFG_FLIP, flip, 1'b1);
        cfg_write(CFG_MIRROR, mirror, 1'b0);
    endtask

    // Each byte leaving the block is matched against the oldest prediction.
    always @(posedge clk)
    begin
        disp_byte_t exp_b;
        if (rst_n && byte_ch.valid && byte_ch.ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected byte: got out_byte=%02h eot=%0b last=%0b",
                         $time, byte_ch.out_byte, byte_ch.end_of_transfer, byte_ch.last);
                error_count++;
            end
            else
            begin
                exp_b = expected_bytes.pop_front();
                if (byte_ch.out_byte !== exp_b.data || byte_ch.end_of_transfer !== exp_b.eot
                    || byte_ch.last !== exp_b.fin)
                begin
                    $display("%0t: byte mismatch: expected out_byte=%02h eot=%0b last=%0b, got out_byte=%02h eot=%0b last=%0b",
                             $time, exp_b.data, exp_b.eot, exp_b.fin,
                             byte_ch.out_byte, byte_ch.end_of_transfer, byte_ch.last);
                    error_count++;
                end
            end
        end
        byte_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Walks every glyph index, the blank one included, across all six positions.
    task automatic test_glyph_table();
        logic [7:0] levels [0:5] = '{8'd0, 8'd3, 8'd7, 8'd8, 8'd200, 8'd255};
        for (int i = 0; i < 6; i++)
            send_frame(make_frame(i * 6, 1, i[0], 1'b0, levels[i]));
    endtask

    task automatic test_control_byte();
        send_frame(make_frame(8, 0, 1'b1, 1'b0, 8'd0));
        send_frame(make_frame(8, 0, 1'b0, 1'b0, 8'd7));
        send_frame(make_frame(8, 0, 1'b1, 1'b0, 8'd8));
        send_frame(make_frame(31, 0, 1'b0, 1'b0, 8'd255));
        send_frame(make_frame(31, 0, 1'b1, 1'b1, 8'd255));
        send_frame(make_frame(0, 0, 1'b0, 1'b1, 8'd0));
    endtask

    task automatic test_display_modes();
        for (int m = 0; m < 4; m++)
        begin
            set_display_mode(m[0], m[1]);
            send_frame(make_frame(0, 1, 1'b1, 1'b0, 8'd5));
            send_frame(make_frame(10 + m * 4, 3, 1'b0, 1'b0, 8'd255));
        end
    endtask

    // Writes to unused register slots must leave both settings alone.
    task automatic test_register_map();
        wait_drained();
        cfg_write(CFG_FLIP, 1'b0, 1'b1);
        cfg_write(CFG_MIRROR, 1'b0, 1'b1);
        cfg_write(CFG_SPARE_2, 1'b1, 1'b1);
        cfg_write(CFG_SPARE_3, 1'b1, 1'b1);
        cfg_write(CFG_SPARE_2, 1'b0, 1'b1);
        cfg_write(CFG_SPARE_3, 1'b0, 1'b0);
        send_frame(make_frame(2, 5, 1'b1, 1'b0, 8'd4));
        wait_drained();
        cfg_write(CFG_FLIP, 1'b1, 1'b1);
        cfg_write(CFG_MIRROR, 1'b1, 1'b1);
        cfg_write(CFG_SPARE_3, 1'b0, 1'b1);
        cfg_write(CFG_SPARE_2, 1'b0, 1'b0);
        send_frame(make_frame(2, 5, 1'b1, 1'b0, 8'd4));
    endtask

    task automatic test_random_traffic(input int count, input int src_pct, input int sink_pct);
        int chunk;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        chunk = 0;
        for (int i = 0; i < count; i++)
        begin
            if (chunk == 0)
            begin
                set_display_mode(1'($urandom_range(1)), 1'($urandom_range(1)));
                chunk = $urandom_range(8, 24);
            end
            // Midway the sender holds off until every pending byte has come out.
            if (i == count / 2)
                wait_drained();
            send_frame(random_frame());
            chunk--;
        end
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        error_count            = 0;
        flip_setting           = 1'b0;
        mirror_setting         = 1'b0;
        src_idle_pct           = 34;
        sink_idle_pct          = 52;
        frame_ch.valid         = 1'b0;
        frame_ch.glyph_0       = '0;
        frame_ch.glyph_1       = '0;
        frame_ch.glyph_2       = '0;
        frame_ch.glyph_3       = '0;
        frame_ch.glyph_4       = '0;
        frame_ch.glyph_5       = '0;
        frame_ch.colon_on      = 1'b0;
        frame_ch.blank_display = 1'b0;
        frame_ch.brightness    = '0;
        byte_ch.ready          = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = '0;
        cfg_ch.data            = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_glyph_table();
        test_control_byte();
        test_display_modes();
        test_register_map();
        test_random_traffic(80, 34, 52);
        test_random_traffic(80, 52, 34);
        test_random_traffic(80, 0, 0);
        wait_drained();

        if (error_count == 0)
            $display("six_digit_segment_frame_encoder test passed");
        else
            $display("six_digit_segment_frame_encoder test failed");
        $finish;
    end

endmodule

>>> files.f
rtl/core/ssfe_pkg.sv
rtl/core/ssfe_if.sv
rtl/core/ssfe_lookup.sv
rtl/core/ssfe_format.sv
rtl/core/ssfe_serializer.sv
rtl/core/six_digit_segment_frame_encoder.sv
rtl/core/ssfe_checker.sv
tb/sv/tb_six_digit_segment_frame_encoder.sv
